### design/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and constants of the sensor timestamp table
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SENSOR_W = 7;
    localparam int STAMP_W  = 32;
    localparam int LIMIT_W  = 31;
    localparam int CFG_IDX_W = 2;

    // request kinds
    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_SINGLE = 2'd1;
    localparam logic [1:0] REQ_SCAN   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE = 2'd1;

    // register reset values
    localparam logic [LIMIT_W-1:0] EXPIRE_RESET  = 31'd1200000;
    localparam logic [LIMIT_W-1:0] MIN_AGE_RESET = 31'd400000;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SENSOR_W-1:0] sensor_index;
        logic [STAMP_W-1:0]  stamp_in;
        logic [STAMP_W-1:0]  now_ticks;
    } t_in_word;

    typedef struct packed {
        logic                found;
        logic [SENSOR_W-1:0] sensor_out;
        logic [STAMP_W-1:0]  stamp_out;
    } t_out_word;

endpackage

### design/sst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sensor_timestamp_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_timestamp_table_top
// per-sensor trigger timestamp store with request and lost-scan lookups
// ----------------------------------------------------------------------------
// The block holds one 32-bit trigger stamp per track sensor in a ram, with a
// flip-flop live bit per entry that reset clears, so the table is empty right
// after reset with no clearing pass. Ages are taken against a down-counting
// timer as stamp minus now, read as a signed 32-bit value. One word is taken
// at a time and each gives exactly one result word. A single request makes
// one ram read, and a lost scan reads the ram one entry per cycle in
// ascending order; the scan stops early at its first hit. The finished result
// sits in an output register, so a new word is taken while it waits.
// Configuration writes are always ready and must come while the block is idle.
// ----------------------------------------------------------------------------
module sensor_timestamp_table_top #(
    parameter int NUM_SENSORS = 80
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sst_pkg::t_in_word                  i_in,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sst_pkg::t_out_word                 o_out,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sst_pkg::LIMIT_W-1:0]        i_cfg_data
);

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SENSORS - 1);
    // compare index one bit wider so a full 128-entry table still works
    localparam logic [sst_pkg::SENSOR_W:0] IDX_LIMIT = (sst_pkg::SENSOR_W + 1)'(NUM_SENSORS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // age above limit: positive difference that exceeds the limit
    function automatic logic f_older(input logic [sst_pkg::STAMP_W-1:0] stamp,
                                     input logic [sst_pkg::STAMP_W-1:0] now,
                                     input logic [sst_pkg::LIMIT_W-1:0] limit);
        logic [sst_pkg::STAMP_W-1:0] diff;
        diff = stamp - now;
        return !diff[sst_pkg::STAMP_W-1] && (diff[sst_pkg::LIMIT_W-1:0] > limit);
    endfunction

    // control state
    t_state                       r_state, n_state;
    logic [NUM_SENSORS-1:0]       r_live, n_live;
    logic [AW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_out_valid, n_out_valid;
    logic [sst_pkg::LIMIT_W-1:0]  r_cfg_expire;
    logic [sst_pkg::LIMIT_W-1:0]  r_cfg_min_age;

    // payload
    sst_pkg::t_in_word            r_in;
    sst_pkg::t_out_word           r_res, n_res;
    sst_pkg::t_out_word           r_out, n_out;

    // ram side
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [sst_pkg::STAMP_W-1:0]  ram_rdata;

    logic                         in_accept;
    logic                         in_range;
    logic [AW-1:0]                in_idx;
    logic                         out_free;
    logic                         entry_live;
    logic                         is_expired;
    logic                         is_min_age;

    sst_ram #(
        .WIDTH (sst_pkg::STAMP_W),
        .DEPTH (NUM_SENSORS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_idx),
        .i_wdata (i_in.stamp_in),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_range    = {1'b0, i_in.sensor_index} < IDX_LIMIT;
    assign in_idx      = i_in.sensor_index[AW-1:0];
    assign out_free    = !r_out_valid || !i_out_stall;

    // the entry read last cycle; a cleared live bit reads as empty
    assign entry_live  = r_live[r_rd_idx];
    assign is_expired  = f_older(ram_rdata, r_in.now_ticks, r_cfg_expire);
    assign is_min_age  = f_older(ram_rdata, r_in.now_ticks, r_cfg_min_age);

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_raddr   = r_rd_idx;
        ram_we      = 1'b0;

        // result word taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res.found      = 1'b0;
                    n_res.sensor_out = i_in.sensor_index;
                    n_res.stamp_out  = '0;
                    n_state          = S_DONE;
                    case (i_in.req_type)
                        sst_pkg::REQ_RECORD: begin
                            if (in_range) begin
                                ram_we         = 1'b1;
                                // a zero stamp leaves the entry empty
                                n_live[in_idx] = (i_in.stamp_in != '0);
                            end
                        end
                        sst_pkg::REQ_SINGLE: begin
                            if (in_range) begin
                                ram_raddr = in_idx;
                                n_state   = S_READ;
                            end
                        end
                        sst_pkg::REQ_SCAN: begin
                            ram_raddr        = '0;
                            n_res.sensor_out = '0;
                            n_state          = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (entry_live) begin
                    n_live[r_rd_idx] = 1'b0;
                    if (!is_expired) begin
                        n_res.found     = 1'b1;
                        n_res.stamp_out = ram_rdata;
                    end
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // next entry is read while this one is judged
                ram_raddr = r_rd_idx + AW'(1);
                if (entry_live && is_expired) begin
                    n_live[r_rd_idx] = 1'b0;
                end else if (entry_live && is_min_age) begin
                    n_live[r_rd_idx] = 1'b0;
                    n_res.found      = 1'b1;
                    n_res.sensor_out = sst_pkg::SENSOR_W'(r_rd_idx);
                    n_res.stamp_out  = ram_rdata;
                    n_state          = S_DONE;
                end
                if (r_rd_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rd_idx = ram_raddr;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_live        <= '0;
            r_rd_idx      <= '0;
            r_out_valid   <= 1'b0;
            r_cfg_expire  <= sst_pkg::EXPIRE_RESET;
            r_cfg_min_age <= sst_pkg::MIN_AGE_RESET;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sst_pkg::CFG_EXPIRE:  r_cfg_expire  <= i_cfg_data;
                    sst_pkg::CFG_MIN_AGE: r_cfg_min_age <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    // a reported stamp is never the empty code
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> (r_out.stamp_out != '0))
        else $error("found result with zero stamp");

    // a lost scan word starts the ram walk on the next cycle
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.req_type == sst_pkg::REQ_SCAN)
            |=> (r_state == S_SCAN && r_rd_idx == '0))
        else $error("scan did not start at entry zero");

    // the scan walk never leaves the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= LAST_IDX))
        else $error("scan index beyond table");

    // a finished item waiting on the output register holds the input closed
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

endmodule
